// ----- rtl/qlt_pkg.sv -----
// Shared constants, codes and control types of the Q table update block.
`default_nettype none
package qlt_pkg;

    localparam int NUM_STATES  = 256;
    localparam int NUM_ACTIONS = 8;
    localparam int Q_WIDTH     = 24;

    localparam int STATE_W = $clog2(NUM_STATES);
    localparam int ACT_W   = $clog2(NUM_ACTIONS);
    localparam int ADDR_W  = STATE_W + ACT_W;
    localparam int DEPTH   = NUM_STATES * NUM_ACTIONS;

    localparam int STATE_IN_W = 8;
    localparam int ACT_IN_W   = 3;
    localparam int REWARD_W   = 16;
    localparam int QV_W       = 24;
    localparam int FRAC_W     = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT   = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] LEARN_RATE_RST = CFG_DATA_W'(6554);
    localparam logic [CFG_DATA_W-1:0] DISCOUNT_RST   = CFG_DATA_W'(62259);

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic              load_in;
        logic              rd_en;
        logic              rd_next;
        logic              rd_taken;
        logic              scan_rd;
        logic [ACT_W-1:0]  act;
        logic              clr_we;
        logic [ADDR_W-1:0] clr_addr;
        logic              q_load;
        logic              diff_load;
        logic              mul_load;
        logic              wb;
        logic              out_load;
    } qlt_cmd_t;

    typedef struct packed {
        logic op_update;
        logic out_busy;
    } qlt_sts_t;

endpackage
`default_nettype wire

// ----- rtl/qlt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module qlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/qlt_ctrl.sv -----
// Controller state machine: table clear, row scans, update sequence, result hand-off.
`default_nettype none
module qlt_ctrl
    import qlt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire qlt_sts_t sts,
    output qlt_cmd_t      cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SCAN_A = 4'd2;
    localparam logic [3:0] S_WAIT_A = 4'd3;
    localparam logic [3:0] S_LOAD_Q = 4'd4;
    localparam logic [3:0] S_DIFF   = 4'd5;
    localparam logic [3:0] S_MUL_A  = 4'd6;
    localparam logic [3:0] S_WRITE  = 4'd7;
    localparam logic [3:0] S_SCAN_B = 4'd8;
    localparam logic [3:0] S_WAIT_B = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              scan_last;
    logic              clr_last;

    assign scan_last = (cnt_reg[ACT_W-1:0] == ACT_W'(NUM_ACTIONS - 1));
    assign clr_last  = (cnt_reg == ADDR_W'(DEPTH - 1));
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.act      = cnt_reg[ACT_W-1:0];
        cmd.clr_addr = cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                cnt_next   = cnt_reg + ADDR_W'(1);
                if (clr_last)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SCAN_A;
                end
            end
            S_SCAN_A:
            begin
                cmd.rd_en   = 1'b1;
                cmd.scan_rd = 1'b1;
                cmd.rd_next = sts.op_update;
                cnt_next    = cnt_reg + ADDR_W'(1);
                if (scan_last)
                begin
                    cnt_next   = '0;
                    state_next = S_WAIT_A;
                end
            end
            S_WAIT_A:
            begin
                if (sts.op_update)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_taken = 1'b1;
                    state_next   = S_LOAD_Q;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LOAD_Q:
            begin
                cmd.q_load = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = S_MUL_A;
            end
            S_MUL_A:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wb     = 1'b1;
                state_next = S_SCAN_B;
            end
            S_SCAN_B:
            begin
                cmd.rd_en   = 1'b1;
                cmd.scan_rd = 1'b1;
                cnt_next    = cnt_reg + ADDR_W'(1);
                if (scan_last)
                begin
                    cnt_next   = '0;
                    state_next = S_WAIT_B;
                end
            end
            S_WAIT_B:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/qlt_dp.sv -----
// Datapath: Q table RAM, argmax scan, fixed-point update arithmetic, output register.
`default_nettype none
module qlt_dp
    import qlt_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire qlt_cmd_t                     cmd,
    output qlt_sts_t                          sts,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                         in_op,
    input  wire logic [STATE_IN_W-1:0]        in_cur_state,
    input  wire logic [ACT_IN_W-1:0]          in_taken_action,
    input  wire logic signed [REWARD_W-1:0]   in_reward,
    input  wire logic [STATE_IN_W-1:0]        in_next_state,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ACT_IN_W-1:0]               out_action,
    output logic signed [QV_W-1:0]            out_q_value,
    output logic                              out_saturated
);

    localparam int GPROD_W = Q_WIDTH + FRAC_W + 1;
    localparam int GRND_W  = GPROD_W - FRAC_W;
    localparam int DIFF_W  = Q_WIDTH + 3;
    localparam int APROD_W = DIFF_W + FRAC_W + 1;
    localparam int ADJ_W   = APROD_W - FRAC_W;
    localparam int NQ_W    = DIFF_W + 2;

    localparam logic signed [GPROD_W-1:0] G_HALF = GPROD_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [APROD_W-1:0] A_HALF = APROD_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [NQ_W-1:0] NQ_MAX = NQ_W'((64'sd1 <<< (Q_WIDTH - 1)) - 64'sd1);
    localparam logic signed [NQ_W-1:0] NQ_MIN = NQ_W'(-(64'sd1 <<< (Q_WIDTH - 1)));

    logic [CFG_DATA_W-1:0] learn_rate_reg, learn_rate_next;
    logic [CFG_DATA_W-1:0] discount_reg, discount_next;

    logic                       op_reg;
    logic [STATE_W-1:0]         cur_reg;
    logic [STATE_W-1:0]         nxt_reg;
    logic [ACT_W-1:0]           taken_reg;
    logic signed [REWARD_W-1:0] reward_reg;

    logic                       cmp_v_reg;
    logic [ACT_W-1:0]           cmp_act_reg;
    logic signed [Q_WIDTH-1:0]  best_q_reg;
    logic [ACT_W-1:0]           best_a_reg;

    logic signed [Q_WIDTH-1:0]  q_old_reg;
    logic signed [GPROD_W-1:0]  gprod_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [APROD_W-1:0]  aprod_reg;
    logic signed [Q_WIDTH-1:0]  res_q_reg;
    logic                       res_sat_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [ACT_IN_W-1:0]        out_act_reg;
    logic signed [QV_W-1:0]     out_q_reg;
    logic                       out_sat_reg;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [Q_WIDTH-1:0]         ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [Q_WIDTH-1:0]         ram_rdata;
    logic signed [Q_WIDTH-1:0]  rd_q;

    logic signed [GPROD_W-1:0]  gsum;
    logic signed [GRND_W-1:0]   grnd;
    logic signed [DIFF_W-1:0]   diff_next;
    logic signed [APROD_W-1:0]  asum;
    logic signed [ADJ_W-1:0]    adj;
    logic signed [NQ_W-1:0]     nq;
    logic signed [Q_WIDTH-1:0]  nq_sat;
    logic                       nq_clamped;

    qlt_ram #(
        .WIDTH (Q_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_we    = cmd.clr_we | cmd.wb;
    assign ram_waddr = cmd.clr_we ? cmd.clr_addr : {cur_reg, taken_reg};
    assign ram_wdata = cmd.clr_we ? '0 : nq_sat;
    assign ram_raddr = {(cmd.rd_next ? nxt_reg : cur_reg),
                        (cmd.rd_taken ? taken_reg : cmd.act)};
    assign rd_q      = $signed(ram_rdata);

    always_comb
    begin
        learn_rate_next = learn_rate_reg;
        discount_next   = discount_reg;
        if (cfg_we)
        begin
            if (cfg_index == REG_LEARN_RATE)
            begin
                learn_rate_next = cfg_data;
            end
            else if (cfg_index == REG_DISCOUNT)
            begin
                discount_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= LEARN_RATE_RST;
            discount_reg   <= DISCOUNT_RST;
        end
        else
        begin
            learn_rate_reg <= learn_rate_next;
            discount_reg   <= discount_next;
        end
    end

    assign gsum = gprod_reg + G_HALF;
    assign grnd = gsum[GPROD_W-1:FRAC_W];
    assign diff_next = DIFF_W'(reward_reg) + DIFF_W'(grnd) - DIFF_W'(q_old_reg);
    assign asum = aprod_reg + A_HALF;
    assign adj  = asum[APROD_W-1:FRAC_W];
    assign nq   = NQ_W'(q_old_reg) + NQ_W'(adj);

    always_comb
    begin
        nq_clamped = 1'b0;
        nq_sat     = Q_WIDTH'(nq);
        if (nq > NQ_MAX)
        begin
            nq_clamped = 1'b1;
            nq_sat     = Q_WIDTH'(NQ_MAX);
        end
        else if (nq < NQ_MIN)
        begin
            nq_clamped = 1'b1;
            nq_sat     = Q_WIDTH'(NQ_MIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= in_op;
            cur_reg    <= STATE_W'(in_cur_state);
            nxt_reg    <= STATE_W'(in_next_state);
            taken_reg  <= ACT_W'(in_taken_action);
            reward_reg <= in_reward;
        end
        cmp_act_reg <= cmd.act;
        if (cmp_v_reg && ((cmp_act_reg == '0) || (rd_q > best_q_reg)))
        begin
            best_q_reg <= rd_q;
            best_a_reg <= cmp_act_reg;
        end
        if (cmd.q_load)
        begin
            q_old_reg <= rd_q;
            gprod_reg <= $signed({1'b0, discount_reg}) * best_q_reg;
        end
        if (cmd.diff_load)
        begin
            diff_reg <= diff_next;
        end
        if (cmd.mul_load)
        begin
            aprod_reg <= $signed({1'b0, learn_rate_reg}) * diff_reg;
        end
        if (cmd.wb)
        begin
            res_q_reg   <= nq_sat;
            res_sat_reg <= nq_clamped;
        end
        if (cmd.out_load)
        begin
            out_act_reg <= ACT_IN_W'(best_a_reg);
            if (op_reg == OP_UPDATE)
            begin
                out_q_reg   <= QV_W'(res_q_reg);
                out_sat_reg <= res_sat_reg;
            end
            else
            begin
                out_q_reg   <= QV_W'(best_q_reg);
                out_sat_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cmp_v_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cmp_v_reg     <= cmd.scan_rd;
        end
    end

    assign sts.op_update = (op_reg == OP_UPDATE);
    assign sts.out_busy  = out_valid_reg & ~out_ready;

    assign out_valid     = out_valid_reg;
    assign out_action    = out_act_reg;
    assign out_q_value   = out_q_reg;
    assign out_saturated = out_sat_reg;

endmodule
`default_nettype wire

// ----- rtl/q_learning_table_update.sv -----
// Top level of the tabular Q-learning update block: stream ports, config port, wiring.
//
// Usage:
// - s_axis carries one item per transfer: tuser is op (select or update), tdata holds
//   cur_state, taken_action, reward and next_state. m_axis returns one result per item:
//   tdata holds greedy_action and q_value, tuser the saturation flag.
// - cfg writes learn_rate (index 0) or discount (index 1); other indexes are dropped.
//   cfg_ready is always high; write only while no item is in flight.
// - Each item is served through the single RAM read port: a select does an 8-entry
//   row scan for the argmax; an update adds the Q(s,a) read, two multiply stages,
//   the write-back and a second row scan of cur_state.
// - One item is in work at a time; the next item is taken once the result has been
//   placed in the output register, even while that result still waits.
// - After reset the block clears the 2048-entry table, one entry a cycle, with
//   s_axis_tready low until the clear is done; config writes are taken meanwhile.
// - When m_axis_tready is low the result holds in the output register and the
//   controller waits before loading the next one.
`default_nettype none
module q_learning_table_update
    import qlt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // cur_state[7:0], taken_action[10:8], reward[26:11], next_state[34:27], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op[0]
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // greedy_action[2:0], q_value[26:3], zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // saturated[0]
    output logic                        m_axis_tuser
);

    qlt_cmd_t               cmd;
    qlt_sts_t               sts;
    logic [ACT_IN_W-1:0]    greedy_action;
    logic signed [QV_W-1:0] q_value;

    assign cfg_ready = 1'b1;

    qlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    qlt_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_op           (s_axis_tuser),
        .in_cur_state    (s_axis_tdata[7:0]),
        .in_taken_action (s_axis_tdata[10:8]),
        .in_reward       ($signed(s_axis_tdata[26:11])),
        .in_next_state   (s_axis_tdata[34:27]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_action      (greedy_action),
        .out_q_value     (q_value),
        .out_saturated   (m_axis_tuser)
    );

    assign m_axis_tdata = {5'b0, q_value, greedy_action};

endmodule
`default_nettype wire
